// ===== rtl/pisd_pkg.sv =====
// Shared types and constants for the packed-slot interpolation decoder.
// Holds the prime, the binomial bound table and the accumulator control struct.
// No dependencies; the residue, accumulator and top-level files refer to it by scoped names.
`default_nettype none

package pisd_pkg;

  localparam logic [17:0] PRIME = 18'd65537;

  // Accumulator control: fire moves one product into the sum, last ends the coefficient.
  typedef struct packed {
    logic fire;
    logic last;
  } pisd_acc_ctl_t;

  // C(c + m, m), indexed [m][c] for m in 0..7 and c in 0..15.
  localparam logic [17:0] BOUND_TBL [0:7][0:15] = '{
    '{18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1,
      18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1},
    '{18'd1, 18'd2, 18'd3, 18'd4, 18'd5, 18'd6, 18'd7, 18'd8,
      18'd9, 18'd10, 18'd11, 18'd12, 18'd13, 18'd14, 18'd15, 18'd16},
    '{18'd1, 18'd3, 18'd6, 18'd10, 18'd15, 18'd21, 18'd28, 18'd36,
      18'd45, 18'd55, 18'd66, 18'd78, 18'd91, 18'd105, 18'd120, 18'd136},
    '{18'd1, 18'd4, 18'd10, 18'd20, 18'd35, 18'd56, 18'd84, 18'd120,
      18'd165, 18'd220, 18'd286, 18'd364, 18'd455, 18'd560, 18'd680, 18'd816},
    '{18'd1, 18'd5, 18'd15, 18'd35, 18'd70, 18'd126, 18'd210, 18'd330,
      18'd495, 18'd715, 18'd1001, 18'd1365, 18'd1820, 18'd2380, 18'd3060, 18'd3876},
    '{18'd1, 18'd6, 18'd21, 18'd56, 18'd126, 18'd252, 18'd462, 18'd792,
      18'd1287, 18'd2002, 18'd3003, 18'd4368, 18'd6188, 18'd8568, 18'd11628,
      18'd15504},
    '{18'd1, 18'd7, 18'd28, 18'd84, 18'd210, 18'd462, 18'd924, 18'd1716,
      18'd3003, 18'd5005, 18'd8008, 18'd12376, 18'd18564, 18'd27132, 18'd38760,
      18'd54264},
    '{18'd1, 18'd8, 18'd36, 18'd120, 18'd330, 18'd792, 18'd1716, 18'd3432,
      18'd6435, 18'd11440, 18'd19448, 18'd31824, 18'd50388, 18'd77520, 18'd116280,
      18'd170544}
  };

endpackage

`default_nettype wire

// ===== rtl/pisd_in_if.sv =====
// Input channel of the decoder: one (weight, slot value) point per beat.
// Standalone interface, no dependencies.
`default_nettype none

interface pisd_in_if;
  logic               valid;
  logic               ready;
  logic [16:0]        weight;
  logic signed [63:0] slot_value;
  logic [3:0]         coeff_index;
  logic               last_point;

  modport source (output valid, weight, slot_value, coeff_index, last_point, input ready);
  modport sink   (input valid, weight, slot_value, coeff_index, last_point, output ready);
endinterface

`default_nettype wire

// ===== rtl/pisd_out_if.sv =====
// Result channel of the decoder: one decoded coefficient per beat.
// Standalone interface, no dependencies.
`default_nettype none

interface pisd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coeff_out;
  logic [16:0] lifted_value;
  logic        coeff_bit;
  logic        bound_violation;

  modport source (output valid, coeff_out, lifted_value, coeff_bit, bound_violation,
                  input ready);
  modport sink   (input valid, coeff_out, lifted_value, coeff_bit, bound_violation,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/pisd_cfg_if.sv =====
// Configuration write channel of the decoder: carries the multiplication count.
// Standalone interface, no dependencies.
`default_nettype none

interface pisd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] mults_count;

  modport source (output valid, mults_count, input ready);
  modport sink   (input valid, mults_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/pisd_residue.sv =====
// Canonical residues mod 65537 of the weight and of the signed slot value.
// Uses pisd_pkg for the prime.
`default_nettype none

module pisd_residue (
  input  wire logic [16:0]        weight,
  input  wire logic signed [63:0] slot_value,
  output logic [16:0]             weight_res,
  output logic [16:0]             slot_res
);

  logic [19:0] fold;
  logic [17:0] fold2;
  logic [17:0] fold2_sub;
  logic [17:0] w_sub;

  // 2^16 is -1 mod 65537, so the digits fold with alternating sign. The top
  // digit carries the sign of the value. Adding twice the prime keeps it positive.
  always_comb begin
    fold = 20'd131074
         + {4'b0, slot_value[15:0]}
         + {4'b0, slot_value[47:32]}
         - {4'b0, slot_value[31:16]}
         - {{4{slot_value[63]}}, slot_value[63:48]};
    fold2     = {2'b0, fold[15:0]} + pisd_pkg::PRIME - {15'b0, fold[18:16]};
    fold2_sub = fold2 - pisd_pkg::PRIME;
    slot_res  = (fold2 >= pisd_pkg::PRIME) ? fold2_sub[16:0] : fold2[16:0];

    w_sub      = {1'b0, weight} - pisd_pkg::PRIME;
    weight_res = ({1'b0, weight} >= pisd_pkg::PRIME) ? w_sub[16:0] : weight;
  end

endmodule

`default_nettype wire

// ===== rtl/pisd_accum.sv =====
// Product reduction mod 65537, running accumulator and bound comparison.
// Uses pisd_pkg for the prime and the control struct.
`default_nettype none

module pisd_accum (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pisd_pkg::pisd_acc_ctl_t ctl,
  input  wire logic [33:0]            product,
  input  wire logic [17:0]            bound,
  output logic [16:0]                 value,
  output logic                        violation
);

  logic [16:0] acc_r;
  logic [16:0] acc_nxt;
  logic [17:0] red;
  logic [17:0] red_sub;
  logic [16:0] term;
  logic [17:0] sum;
  logic [17:0] sum_sub;

  // The product is at most 2^32, so one fold and one subtract give the residue.
  always_comb begin
    red     = {2'b0, product[15:0]} + {16'b0, product[33:32]} + pisd_pkg::PRIME
            - {2'b0, product[31:16]};
    red_sub = red - pisd_pkg::PRIME;
    term    = (red >= pisd_pkg::PRIME) ? red_sub[16:0] : red[16:0];
    sum     = {1'b0, acc_r} + {1'b0, term};
    sum_sub = sum - pisd_pkg::PRIME;
    value   = (sum >= pisd_pkg::PRIME) ? sum_sub[16:0] : sum[16:0];
    violation = {1'b0, value} > bound;

    acc_nxt = acc_r;
    if (ctl.fire) begin
      acc_nxt = ctl.last ? 17'd0 : value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 17'd0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/packed_slot_interpolation_decode.sv =====
// Top level of the packed-slot interpolation decoder.
// Depends on pisd_pkg, the three channel interfaces, pisd_residue and pisd_accum.
//
// Usage: points for one coefficient arrive on in_ch, one per beat, each with a
// weight, a signed slot value, the coefficient index and a last flag. The block
// reduces both to residues mod 65537, multiplies them and adds the product into
// a running sum mod 65537. The beat flagged last produces one beat on out_ch with
// the sum, its low bit and a flag that is set when the sum exceeds
// C(coeff + m, m), m being the multiplication count; the sum then restarts at 0.
// cfg_ch writes the multiplication count; it is always ready and is meant to be
// written only while no points are in flight.
// Throughput is one point per cycle while the result is not stalled. The pipeline
// has four register stages: input capture, residues with bound lookup, the 17x17
// multiply, and the result register fed by the reduce-and-accumulate step.
// The accumulator loop, one fold, add and compare, feeds back into the sum
// register through combinational logic only.
// Reset (synchronous, active low) empties the pipeline, clears the sum and sets
// the count to 1. When the receiver stalls, the result holds and stages behind it
// keep filling bubbles; in_ch.ready falls only once every stage holds a point.
`default_nettype none

module packed_slot_interpolation_decode (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pisd_cfg_if.sink    cfg_ch,
  pisd_in_if.sink     in_ch,
  pisd_out_if.source  out_ch
);

  // Configuration register.
  logic [2:0] mults_r;

  // Stage 0: captured input beat.
  logic               v0_r;
  logic [16:0]        w0_r;
  logic signed [63:0] s0_r;
  logic [3:0]         c0_r;
  logic               l0_r;

  // Stage 1: residues and the bound for this coefficient.
  logic        v1_r;
  logic [16:0] wres1_r;
  logic [16:0] sres1_r;
  logic [3:0]  c1_r;
  logic        l1_r;
  logic [17:0] bound1_r;

  // Stage 2: raw product.
  logic        v2_r;
  logic [33:0] prod2_r;
  logic [3:0]  c2_r;
  logic        l2_r;
  logic [17:0] bound2_r;

  // Result register.
  logic        vo_r;
  logic [3:0]  co_r;
  logic [16:0] valo_r;
  logic        viol_r;

  logic        out_free;
  logic        s2_go;
  logic        s2_free;
  logic        s1_free;
  logic        s0_free;
  logic [16:0] wres;
  logic [16:0] sres;
  logic [16:0] acc_value;
  logic        acc_viol;
  pisd_pkg::pisd_acc_ctl_t acc_ctl;

  // A stage may load when it is empty or when its content moves on this cycle.
  // Stage 2 drains into the accumulator and, on a last point, into the result.
  assign out_free = !vo_r || out_ch.ready;
  assign s2_go    = v2_r && out_free;
  assign s2_free  = !v2_r || out_free;
  assign s1_free  = !v1_r || s2_free;
  assign s0_free  = !v0_r || s1_free;

  assign in_ch.ready  = s0_free;
  assign cfg_ch.ready = 1'b1;

  assign acc_ctl.fire = s2_go;
  assign acc_ctl.last = l2_r;

  pisd_residue u_residue (
    .weight     (w0_r),
    .slot_value (s0_r),
    .weight_res (wres),
    .slot_res   (sres)
  );

  pisd_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (acc_ctl),
    .product   (prod2_r),
    .bound     (bound2_r),
    .value     (acc_value),
    .violation (acc_viol)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mults_r <= 3'd1;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      vo_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mults_r <= cfg_ch.mults_count;
      end
      if (s0_free) begin
        v0_r <= in_ch.valid;
      end
      if (s1_free) begin
        v1_r <= v0_r;
      end
      if (s2_free) begin
        v2_r <= v1_r;
      end
      if (out_free) begin
        vo_r <= s2_go && l2_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s0_free && in_ch.valid) begin
      w0_r <= in_ch.weight;
      s0_r <= in_ch.slot_value;
      c0_r <= in_ch.coeff_index;
      l0_r <= in_ch.last_point;
    end
    if (s1_free && v0_r) begin
      wres1_r  <= wres;
      sres1_r  <= sres;
      c1_r     <= c0_r;
      l1_r     <= l0_r;
      bound1_r <= pisd_pkg::BOUND_TBL[mults_r][c0_r];
    end
    if (s2_free && v1_r) begin
      prod2_r  <= {17'b0, wres1_r} * {17'b0, sres1_r};
      c2_r     <= c1_r;
      l2_r     <= l1_r;
      bound2_r <= bound1_r;
    end
    if (s2_go && l2_r) begin
      co_r   <= c2_r;
      valo_r <= acc_value;
      viol_r <= acc_viol;
    end
  end

  assign out_ch.valid           = vo_r;
  assign out_ch.coeff_out       = co_r;
  assign out_ch.lifted_value    = valo_r;
  assign out_ch.coeff_bit       = valo_r[0];
  assign out_ch.bound_violation = viol_r;

  // Every bound is at least 1, so a flagged result cannot be 0 or 1.
  a_viol_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bound_violation) |-> (out_ch.lifted_value > 17'd1))
    else $error("bound violation flagged on a value of 0 or 1");

  // Results stay canonical residues.
  a_canonical: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, out_ch.lifted_value} < pisd_pkg::PRIME))
    else $error("result is not below 65537");

  // A result is raised only by a last point leaving stage 2.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vo_r) |-> $past(v2_r && l2_r))
    else $error("result appeared without a last point");

  // Input backpressure appears only when the whole pipeline is full and stalled.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v0_r && v1_r && v2_r && vo_r && !out_ch.ready))
    else $error("input stalled while a stage could take a point");

endmodule

`default_nettype wire
